// File: hdl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator
package ffba_pkg;

  // Field widths fixed by the item format
  localparam int unsigned FieldW = 20;
  localparam int unsigned LimitW = 21;
  localparam logic [LimitW-1:0] LimitReset = 21'd1048576;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NULL    = 2'd1,
    ST_OOM     = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  // Request item
  typedef struct packed {
    command_e           command;
    logic [FieldW-1:0]  request_size;
    logic [FieldW-1:0]  user_address;
  } req_t;

  // Result item
  typedef struct packed {
    logic [FieldW-1:0]  granted_address;
    status_e            status;
  } rsp_t;

endpackage

// File: hdl/ffba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/ffba_ctrl.sv
// Allocation sequencer: walks the block table through the RAM read port,
// one entry a cycle, and writes back the hit or the appended block.
module ffba_ctrl #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned ADDR_BITS    = 20,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ffba_pkg::LimitW-1:0]   limit_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  ffba_pkg::req_t                req_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output ffba_pkg::rsp_t                res_o
);

  localparam int unsigned IDXW = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW   = ((ADDR_BITS > ffba_pkg::LimitW) ? ADDR_BITS
                                                                 : ffba_pkg::LimitW) + 2;
  localparam int unsigned ENTW = ADDR_BITS + ffba_pkg::FieldW + 1;
  localparam logic [CW-1:0]   HDR  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0]   CAP  = (CW'(1) << ADDR_BITS) - CW'(1);
  localparam logic [CNTW-1:0] FULL = CNTW'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  ffba_pkg::command_e          cmd_q, cmd_d;
  logic [ffba_pkg::FieldW-1:0] size_q, size_d;
  logic [ffba_pkg::FieldW-1:0] user_q, user_d;
  logic [CNTW-1:0]             rd_idx_q, rd_idx_d;
  logic                        rd_pend_q, rd_pend_d;
  logic [IDXW-1:0]             chk_idx_q, chk_idx_d;
  logic [CNTW-1:0]             cnt_q, cnt_d;
  logic [ADDR_BITS-1:0]        brk_q, brk_d;
  ffba_pkg::rsp_t              rsp_q, rsp_d;

  // RAM ports
  logic                 wr_en, rd_en;
  logic [IDXW-1:0]      wr_addr, rd_addr;
  logic [ENTW-1:0]      wr_data, rd_data;

  // Table entry fields: {free, length, base}
  logic [ADDR_BITS-1:0]        ent_base;
  logic [ffba_pkg::FieldW-1:0] ent_len;
  logic                        ent_free;
  logic [CW-1:0]               ent_addr, brk_addr, end_w, limit;
  logic                        fit, match, hit, exhausted, room;

  ffba_ram #(
    .WIDTH (ENTW),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Decode of the entry read last cycle
  assign ent_base  = rd_data[ADDR_BITS-1:0];
  assign ent_len   = rd_data[ADDR_BITS +: ffba_pkg::FieldW];
  assign ent_free  = rd_data[ENTW-1];
  assign ent_addr  = CW'(ent_base) + HDR;
  assign fit       = ent_free && (ent_len >= size_q);
  assign match     = (ent_addr == CW'(user_q));
  assign hit       = rd_pend_q && ((cmd_q == ffba_pkg::CMD_ALLOC) ? fit : match);
  assign exhausted = !rd_pend_q && (rd_idx_q >= cnt_q);

  // Append check at the break
  assign limit    = (CW'(limit_i) < CAP) ? CW'(limit_i) : CAP;
  assign brk_addr = CW'(brk_q) + HDR;
  assign end_w    = brk_addr + CW'(size_q);
  assign room     = (cnt_q < FULL) && (end_w <= limit);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    size_d    = size_q;
    user_d    = user_q;
    rd_idx_d  = rd_idx_q;
    rd_pend_d = 1'b0;
    chk_idx_d = chk_idx_q;
    cnt_d     = cnt_q;
    brk_d     = brk_q;
    rsp_d     = rsp_q;
    wr_en     = 1'b0;
    wr_addr   = chk_idx_q;
    wr_data   = {ent_free, ent_len, ent_base};
    rd_en     = 1'b0;
    rd_addr   = rd_idx_q[IDXW-1:0];
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d    = req_i.command;
          size_d   = req_i.request_size;
          user_d   = req_i.user_address;
          rd_idx_d = '0;
          if ((req_i.command == ffba_pkg::CMD_ALLOC && req_i.request_size == '0) ||
              (req_i.command == ffba_pkg::CMD_FREE && req_i.user_address == '0)) begin
            rsp_d.granted_address = '0;
            rsp_d.status          = ffba_pkg::ST_NULL;
            state_d               = S_OUT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // reuse or release the matching block
          wr_en   = 1'b1;
          wr_addr = chk_idx_q;
          wr_data = {(cmd_q == ffba_pkg::CMD_FREE), ent_len, ent_base};
          rsp_d.granted_address = (cmd_q == ffba_pkg::CMD_ALLOC) ?
                                  ent_addr[ffba_pkg::FieldW-1:0] : '0;
          rsp_d.status = ffba_pkg::ST_DONE;
          state_d      = S_OUT;
        end else if (exhausted) begin
          rsp_d.granted_address = '0;
          if (cmd_q == ffba_pkg::CMD_FREE) begin
            rsp_d.status = ffba_pkg::ST_UNKNOWN;
          end else if (room) begin
            // append a new block at the break
            wr_en   = 1'b1;
            wr_addr = cnt_q[IDXW-1:0];
            wr_data = {1'b0, size_q, brk_q};
            cnt_d   = cnt_q + CNTW'(1);
            brk_d   = end_w[ADDR_BITS-1:0];
            rsp_d.granted_address = brk_addr[ffba_pkg::FieldW-1:0];
            rsp_d.status          = ffba_pkg::ST_DONE;
          end else begin
            rsp_d.status = ffba_pkg::ST_OOM;
          end
          state_d = S_OUT;
        end else if (rd_idx_q < cnt_q) begin
          // issue the next table read
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          chk_idx_d = rd_idx_q[IDXW-1:0];
          rd_idx_d  = rd_idx_q + CNTW'(1);
        end
      end

      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = rsp_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_idx_q  <= '0;
      rd_pend_q <= 1'b0;
      cnt_q     <= '0;
      brk_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      rd_pend_q <= rd_pend_d;
      cnt_q     <= cnt_d;
      brk_q     <= brk_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    size_q    <= size_d;
    user_q    <= user_d;
    chk_idx_q <= chk_idx_d;
    rsp_q     <= rsp_d;
  end

`ifndef NO_ASSERTIONS
  // table writes happen only while scanning
  a_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_SCAN)
    else $error("table write outside scan");

  // block count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL)
    else $error("block count overflow");

  // block count only ever grows by one
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + CNTW'(1)))
    else $error("block count jumped");

  // a pending read always points at a valid entry
  a_chk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (CNTW'(chk_idx_q) < cnt_q))
    else $error("read of unused table entry");

  // break stays within the address range
  a_brk_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(brk_q) <= CAP)
    else $error("break beyond address cap");
`endif

endmodule

// File: hdl/first_fit_block_allocator_core.sv
// First-fit block allocator. Each item is an allocate or a free; each gives
// exactly one result item. The block table lives in one RAM with one read a
// cycle, and an item that reaches the table is served by that single read
// port walking the table in creation order; null and zero-size requests skip
// the walk and go straight to the result. A finished result waits in an
// output register while the next item is taken. The heap limit register may
// be written at any time the block is idle and is always ready. No clearing
// pass is needed after reset: only table entries below the block count are
// ever read.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned ADDR_BITS    = 20,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ffba_pkg::LimitW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ffba_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ffba_pkg::rsp_t              out_data_o
);

  logic [ffba_pkg::LimitW-1:0] limit_q;
  logic                        req_ready, res_valid, res_ready;
  ffba_pkg::rsp_t              res;
  logic                        out_valid_q, out_valid_d;
  ffba_pkg::rsp_t              out_data_q;

  ffba_ctrl #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .ADDR_BITS    (ADDR_BITS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_i       (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign in_stall_o  = !req_ready;
  assign cfg_ready_o = 1'b1;

  // Heap limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ffba_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Output register: takes a result when empty or being drained
  assign res_ready   = !out_valid_q || !out_stall_i;
  assign out_valid_d = res_valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
